/* rtl/sqvg_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sqvg_pkg
// Shared types, constants and tables for the sphere quad vertex generator.
// ----------------------------------------------------------------------------
package sqvg_pkg;

    localparam int STEP_DEGREES_DEF = 10;
    localparam int FULL_TURN        = 360;
    localparam int QUARTER_TURN     = 90;

    localparam int LAT_W      = 4;
    localparam int LON_W      = 6;
    localparam int RADIUS_W   = 15;
    localparam int COLOR_W    = 8;
    localparam int COORD_W    = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;

    localparam int DEG_W      = 9;
    localparam int IDX_W      = LON_W + 1;
    localparam int DEG_TAB_N  = 1 << IDX_W;
    localparam int MAG_W      = 15;
    localparam int ROM_N      = QUARTER_TURN + 1;
    localparam int ROM_IDX_W  = 7;

    localparam logic [RADIUS_W-1:0] RADIUS_RST = 15'd10650;
    localparam logic [COLOR_W-1:0]  COLOR_RST  = 8'd230;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RADIUS = 2'd0,
        CFG_RED    = 2'd1,
        CFG_GREEN  = 2'd2,
        CFG_BLUE   = 2'd3
    } t_cfg_reg;

    typedef logic [DEG_W-1:0] t_deg_tab [DEG_TAB_N];

    typedef struct packed {
        logic [MAG_W-1:0] sin_mag;
        logic             sin_neg;
        logic [MAG_W-1:0] cos_mag;
        logic             cos_neg;
    } t_trig;

    // sin(d) for d = 0..90 degrees, unsigned Q1.14 magnitude
    localparam logic [MAG_W-1:0] SIN_ROM [ROM_N] = '{
        15'd0,     15'd286,   15'd572,   15'd857,   15'd1143,
        15'd1428,  15'd1713,  15'd1997,  15'd2280,  15'd2563,
        15'd2845,  15'd3126,  15'd3406,  15'd3686,  15'd3964,
        15'd4240,  15'd4516,  15'd4790,  15'd5063,  15'd5334,
        15'd5604,  15'd5872,  15'd6138,  15'd6402,  15'd6664,
        15'd6924,  15'd7182,  15'd7438,  15'd7692,  15'd7943,
        15'd8192,  15'd8438,  15'd8682,  15'd8923,  15'd9162,
        15'd9397,  15'd9630,  15'd9860,  15'd10087, 15'd10311,
        15'd10531, 15'd10749, 15'd10963, 15'd11174, 15'd11381,
        15'd11585, 15'd11786, 15'd11982, 15'd12176, 15'd12365,
        15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255,
        15'd13421, 15'd13583, 15'd13741, 15'd13894, 15'd14044,
        15'd14189, 15'd14330, 15'd14466, 15'd14598, 15'd14726,
        15'd14849, 15'd14968, 15'd15082, 15'd15191, 15'd15296,
        15'd15396, 15'd15491, 15'd15582, 15'd15668, 15'd15749,
        15'd15826, 15'd15897, 15'd15964, 15'd16026, 15'd16083,
        15'd16135, 15'd16182, 15'd16225, 15'd16262, 15'd16294,
        15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382,
        15'd16384
    };

    // angle in degrees, wrapped to one turn, for each step index
    function automatic t_deg_tab build_deg_tab(int step);
        t_deg_tab tab;
        int       acc;
        acc = 0;
        for (int i = 0; i < DEG_TAB_N; i++) begin
            tab[i] = DEG_W'(acc);
            acc    = acc + step;
            if (acc >= FULL_TURN) begin
                acc = acc - FULL_TURN;
            end
        end
        return tab;
    endfunction

endpackage
`default_nettype wire

/* rtl/sphere_quad_vertex_generator.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sphere_quad_vertex_generator
// Four corner vertices of one latitude/longitude patch of a sphere, with the
// configured colour, in signed Q4.12.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+------------------------
//   cell    | in        | i_in_valid / o_in_ready   | lat, lon, lower half
//   vertex  | out       | o_out_valid / i_out_ready | x, y, z, rgb, last
//   config  | in        | i_cfg_we                  | index, data
//
// Each cell yields four corners: the vertex sequencer issues one corner a
// cycle unless the output stalls; vertices then pass the stage registers.
// Reset loads the register defaults and empties the pipeline.
// A waiting vertex with i_out_ready low freezes every stage; the sequencer
// holds its corner.
// ----------------------------------------------------------------------------
module sphere_quad_vertex_generator
    import sqvg_pkg::*;
#(
    parameter int STEP_DEGREES = STEP_DEGREES_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,

    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic [LAT_W-1:0]      i_lat_index,
    input  wire logic [LON_W-1:0]      i_lon_index,
    input  wire logic                  i_lower_half,

    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic signed [COORD_W-1:0]  o_x_coord,
    output logic signed [COORD_W-1:0]  o_y_coord,
    output logic signed [COORD_W-1:0]  o_z_coord,
    output logic [COLOR_W-1:0]         o_red_out,
    output logic [COLOR_W-1:0]         o_green_out,
    output logic [COLOR_W-1:0]         o_blue_out,
    output logic                       o_last_vertex,

    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam t_deg_tab DEG_TAB = build_deg_tab(STEP_DEGREES);
    localparam int P1_W    = RADIUS_W + MAG_W - 1;
    localparam int P2_W    = P1_W + MAG_W - 1;
    localparam int FRAC_Z  = 14;
    localparam int FRAC_XY = 28;

    function automatic logic [COORD_W-1:0] apply_sign(logic [MAG_W-1:0] mag, logic neg);
        logic [COORD_W-1:0] ext;
        ext = {1'b0, mag};
        return neg ? (~ext + 1'b1) : ext;
    endfunction

    // configuration
    logic [RADIUS_W-1:0] r_radius;
    logic [COLOR_W-1:0]  r_red;
    logic [COLOR_W-1:0]  r_green;
    logic [COLOR_W-1:0]  r_blue;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RADIUS_RST;
            r_red    <= COLOR_RST;
            r_green  <= COLOR_RST;
            r_blue   <= COLOR_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_RADIUS: r_radius <= i_cfg_data[RADIUS_W-1:0];
                CFG_RED:    r_red    <= i_cfg_data[COLOR_W-1:0];
                CFG_GREEN:  r_green  <= i_cfg_data[COLOR_W-1:0];
                CFG_BLUE:   r_blue   <= i_cfg_data[COLOR_W-1:0];
                default:    r_radius <= r_radius;
            endcase
        end
    end

    // pipeline advance
    logic advance;
    assign advance = !o_out_valid || i_out_ready;

    // vertex sequencer
    logic             r_busy;
    logic [1:0]       r_k;
    logic [LAT_W-1:0] r_lat;
    logic [LON_W-1:0] r_lon;
    logic             r_flip;
    logic             in_xfer;
    logic             issue;

    assign o_in_ready = !r_busy || (advance && r_k == 2'd3);
    assign in_xfer    = i_in_valid && o_in_ready;
    assign issue      = r_busy && advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_k    <= 2'd0;
        end else if (in_xfer) begin
            r_busy <= 1'b1;
            r_k    <= 2'd0;
        end else if (issue) begin
            r_k <= r_k + 2'd1;
            if (r_k == 2'd3) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_lat  <= i_lat_index;
            r_lon  <= i_lon_index;
            r_flip <= i_lower_half;
        end
    end

    // stage valids
    logic r_v1, r_v2, r_v3, r_v4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_v4        <= 1'b0;
            o_out_valid <= 1'b0;
        end else if (advance) begin
            r_v1        <= issue;
            r_v2        <= r_v1;
            r_v3        <= r_v2;
            r_v4        <= r_v3;
            o_out_valid <= r_v4;
        end
    end

    // stage 1: angles
    logic [IDX_W-1:0] lat_sel;
    logic [IDX_W-1:0] lon_sel;
    logic [DEG_W-1:0] r_deg_lat;
    logic [DEG_W-1:0] r_deg_lon;
    logic             r_flip1;
    logic             r_last1;

    assign lat_sel = IDX_W'(r_lat) + IDX_W'(r_k[0]);
    assign lon_sel = IDX_W'(r_lon) + IDX_W'(r_k[1]);

    // stage 2: sine and cosine
    t_trig trig_lat;
    t_trig trig_lon;
    t_trig r_tlat;
    t_trig r_tlon;
    logic  r_flip2;
    logic  r_last2;

    sqvg_trig u_trig_lat (
        .i_deg  (r_deg_lat),
        .o_trig (trig_lat)
    );

    sqvg_trig u_trig_lon (
        .i_deg  (r_deg_lon),
        .o_trig (trig_lon)
    );

    // stage 3: radius products
    logic [RADIUS_W+MAG_W-1:0] mul_lat;
    logic [RADIUS_W+MAG_W-1:0] mul_z;
    logic [P1_W-1:0]           r_p_lat;
    logic [P1_W-1:0]           r_p_z;
    logic [MAG_W-1:0]          r_slon;
    logic [MAG_W-1:0]          r_clon;
    logic                      r_xneg3, r_yneg3, r_zneg3;
    logic                      r_last3;

    assign mul_lat = r_radius * r_tlat.sin_mag;
    assign mul_z   = r_radius * r_tlat.cos_mag;

    // stage 4: longitude products, z rounding
    logic [P1_W+MAG_W-1:0] mul_x;
    logic [P1_W+MAG_W-1:0] mul_y;
    logic [P1_W:0]         z_sum;
    logic [P2_W-1:0]       r_px;
    logic [P2_W-1:0]       r_py;
    logic [MAG_W-1:0]      r_zmag;
    logic                  r_xneg4, r_yneg4, r_zneg4;
    logic                  r_last4;

    assign mul_x = r_p_lat * r_slon;
    assign mul_y = r_p_lat * r_clon;
    assign z_sum = {1'b0, r_p_z} + (P1_W + 1)'(1 << (FRAC_Z - 1));

    // stage 5: x/y rounding, output register
    logic [P2_W:0] x_sum;
    logic [P2_W:0] y_sum;

    assign x_sum = {1'b0, r_px} + (P2_W + 1)'(1 << (FRAC_XY - 1));
    assign y_sum = {1'b0, r_py} + (P2_W + 1)'(1 << (FRAC_XY - 1));

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_deg_lat <= DEG_TAB[lat_sel];
            r_deg_lon <= DEG_TAB[lon_sel];
            r_flip1   <= r_flip;
            r_last1   <= (r_k == 2'd3);

            r_tlat    <= trig_lat;
            r_tlon    <= trig_lon;
            r_flip2   <= r_flip1;
            r_last2   <= r_last1;

            r_p_lat   <= mul_lat[P1_W-1:0];
            r_p_z     <= mul_z[P1_W-1:0];
            r_slon    <= r_tlon.sin_mag;
            r_clon    <= r_tlon.cos_mag;
            r_xneg3   <= r_tlon.sin_neg ^ r_tlat.sin_neg;
            r_yneg3   <= r_tlon.cos_neg ^ r_tlat.sin_neg;
            r_zneg3   <= r_tlat.cos_neg ^ r_flip2;
            r_last3   <= r_last2;

            r_px      <= mul_x[P2_W-1:0];
            r_py      <= mul_y[P2_W-1:0];
            r_zmag    <= z_sum[FRAC_Z+MAG_W-1:FRAC_Z];
            r_xneg4   <= r_xneg3;
            r_yneg4   <= r_yneg3;
            r_zneg4   <= r_zneg3;
            r_last4   <= r_last3;

            o_x_coord     <= apply_sign(x_sum[FRAC_XY+MAG_W-1:FRAC_XY], r_xneg4);
            o_y_coord     <= apply_sign(y_sum[FRAC_XY+MAG_W-1:FRAC_XY], r_yneg4);
            o_z_coord     <= apply_sign(r_zmag, r_zneg4);
            o_last_vertex <= r_last4;
        end
    end

    assign o_red_out   = r_red;
    assign o_green_out = r_green;
    assign o_blue_out  = r_blue;

    // checks
    a_seq_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> r_busy && r_k == 2'd0)
        else $error("sequencer did not restart on cell transfer");

    a_z_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v4 |-> r_zmag <= r_radius)
        else $error("z magnitude exceeds radius");

    a_x_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v4 |-> r_px <= {r_radius, 28'd0})
        else $error("x product exceeds radius scale");

endmodule
`default_nettype wire

/* rtl/sqvg_trig.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sqvg_trig
// Quadrant fold and quarter-wave ROM lookup: sine and cosine of a whole-degree
// angle as magnitude and sign.
// ----------------------------------------------------------------------------
module sqvg_trig
    import sqvg_pkg::*;
(
    input  wire logic [DEG_W-1:0] i_deg,
    output t_trig                 o_trig
);

    logic [1:0]           quad;
    logic [DEG_W-1:0]     base;
    logic [ROM_IDX_W-1:0] rem;
    logic [ROM_IDX_W-1:0] sin_idx;
    logic [ROM_IDX_W-1:0] cos_idx;

    always_comb begin
        priority if (i_deg >= DEG_W'(3 * QUARTER_TURN)) begin
            quad = 2'd3;
            base = DEG_W'(3 * QUARTER_TURN);
        end else if (i_deg >= DEG_W'(2 * QUARTER_TURN)) begin
            quad = 2'd2;
            base = DEG_W'(2 * QUARTER_TURN);
        end else if (i_deg >= DEG_W'(QUARTER_TURN)) begin
            quad = 2'd1;
            base = DEG_W'(QUARTER_TURN);
        end else begin
            quad = 2'd0;
            base = '0;
        end
        rem     = ROM_IDX_W'(i_deg - base);
        sin_idx = quad[0] ? ROM_IDX_W'(QUARTER_TURN) - rem : rem;
        cos_idx = quad[0] ? rem : ROM_IDX_W'(QUARTER_TURN) - rem;
    end

    assign o_trig.sin_mag = SIN_ROM[sin_idx];
    assign o_trig.sin_neg = quad[1];
    assign o_trig.cos_mag = SIN_ROM[cos_idx];
    assign o_trig.cos_neg = quad[1] ^ quad[0];

endmodule
`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sphere quad vertex generator. Grid cells go in
// through a queue-fed driver and the vertex stream is compared field by field
// against a fixed-point patch predictor. Both sides idle at random, the output
// is held off for a long stretch once, and the registers are reloaded between
// phases, including the radius and colour extremes.
// ----------------------------------------------------------------------------
module tb
    import sqvg_pkg::*;
();

    localparam int CELL_STEP   = 10;
    localparam int LONG_HOLD   = 300;
    localparam int DRAIN       = 10;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic [LAT_W-1:0] lat;
        logic [LON_W-1:0] lon;
        logic             lower;
        int               gap;
    } t_cell;

    typedef struct {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic [COLOR_W-1:0]        red;
        logic [COLOR_W-1:0]        green;
        logic [COLOR_W-1:0]        blue;
        logic                      last;
    } t_vertex;

    // sin of whole degrees 0..90, Q2.14
    localparam int SINE_Q14 [91] = '{
            0,   286,   572,   857,  1143,  1428,  1713,  1997,  2280,  2563,
         2845,  3126,  3406,  3686,  3964,  4240,  4516,  4790,  5063,  5334,
         5604,  5872,  6138,  6402,  6664,  6924,  7182,  7438,  7692,  7943,
         8192,  8438,  8682,  8923,  9162,  9397,  9630,  9860, 10087, 10311,
        10531, 10749, 10963, 11174, 11381, 11585, 11786, 11982, 12176, 12365,
        12551, 12733, 12911, 13085, 13255, 13421, 13583, 13741, 13894, 14044,
        14189, 14330, 14466, 14598, 14726, 14849, 14968, 15082, 15191, 15296,
        15396, 15491, 15582, 15668, 15749, 15826, 15897, 15964, 16026, 16083,
        16135, 16182, 16225, 16262, 16294, 16322, 16344, 16362, 16374, 16382,
        16384
    };

    logic                  i_clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [LAT_W-1:0]      lat_index = '0;
    logic [LON_W-1:0]      lon_index = '0;
    logic                  lower_half = 1'b0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic signed [COORD_W-1:0] x_coord;
    logic signed [COORD_W-1:0] y_coord;
    logic signed [COORD_W-1:0] z_coord;
    logic [COLOR_W-1:0]    red_out;
    logic [COLOR_W-1:0]    green_out;
    logic [COLOR_W-1:0]    blue_out;
    logic                  last_vertex;
    logic                  cfg_we = 1'b0;
    t_cfg_reg              cfg_index = CFG_RADIUS;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    logic [RADIUS_W-1:0]   radius_set = RADIUS_RST;
    logic [COLOR_W-1:0]    red_set    = COLOR_RST;
    logic [COLOR_W-1:0]    green_set  = COLOR_RST;
    logic [COLOR_W-1:0]    blue_set   = COLOR_RST;

    t_cell   cell_q[$];
    t_vertex vertex_q[$];

    int cells_queued   = 0;
    int cells_accepted = 0;
    int vertices_seen  = 0;
    int settings_used  = 1;
    int errors         = 0;
    int hold_asks      = 0;
    int cycles         = 0;

    sphere_quad_vertex_generator #(
        .STEP_DEGREES(CELL_STEP)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_lat_index  (lat_index),
        .i_lon_index  (lon_index),
        .i_lower_half (lower_half),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_x_coord    (x_coord),
        .o_y_coord    (y_coord),
        .o_z_coord    (z_coord),
        .o_red_out    (red_out),
        .o_green_out  (green_out),
        .o_blue_out   (blue_out),
        .o_last_vertex(last_vertex),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic int sine_deg(int unsigned deg);
        int unsigned d;
        int unsigned r;
        d = deg % 360;
        r = d % 90;
        case (d / 90)
            0: return SINE_Q14[r];
            1: return SINE_Q14[90 - r];
            2: return -SINE_Q14[r];
            default: return -SINE_Q14[90 - r];
        endcase
    endfunction

    function automatic int cosine_deg(int unsigned deg);
        return sine_deg(deg % 360 + 90);
    endfunction

    // round the magnitude to nearest (ties away from zero), then apply the sign
    function automatic logic [COORD_W-1:0] round_q12(longint unsigned mag, bit neg,
                                                     int unsigned sh);
        longint unsigned m;
        m = (mag + (64'd1 << (sh - 1))) >> sh;
        if (neg) begin
            m = -m;
        end
        return m[COORD_W-1:0];
    endfunction

    function automatic logic [COORD_W-1:0] planar_coord(int a, int b);
        longint unsigned ma;
        longint unsigned mb;
        ma = (a < 0) ? -a : a;
        mb = (b < 0) ? -b : b;
        return round_q12(longint'(radius_set) * ma * mb, (a < 0) != (b < 0), 28);
    endfunction

    function automatic logic [COORD_W-1:0] height_coord(int c, bit flip);
        longint unsigned mc;
        mc = (c < 0) ? -c : c;
        return round_q12(longint'(radius_set) * mc, (c < 0) != flip, 14);
    endfunction

    task automatic predict_patch(logic [LAT_W-1:0] lat, logic [LON_W-1:0] lon,
                                 logic lower);
        int unsigned lat_deg [2];
        int unsigned lon_deg [2];
        int unsigned la;
        int unsigned lo;
        t_vertex     v;
        lat_deg[0] = (int'(lat) * CELL_STEP) % 360;
        lat_deg[1] = ((int'(lat) + 1) * CELL_STEP) % 360;
        lon_deg[0] = (int'(lon) * CELL_STEP) % 360;
        lon_deg[1] = ((int'(lon) + 1) * CELL_STEP) % 360;
        for (int k = 0; k < 4; k++) begin
            la      = lat_deg[k & 1];
            lo      = lon_deg[(k >> 1) & 1];
            v.x     = planar_coord(sine_deg(lo), sine_deg(la));
            v.y     = planar_coord(cosine_deg(lo), sine_deg(la));
            v.z     = height_coord(cosine_deg(la), lower);
            v.red   = red_set;
            v.green = green_set;
            v.blue  = blue_set;
            v.last  = (k == 3);
            vertex_q.push_back(v);
        end
    endtask

    function automatic int pick_gap();
        if ($urandom_range(0, 99) < 80) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    // driver: present queued cells, predict each one on transfer
    always @(posedge i_clk) begin : drive_cells
        t_cell    head;
        static int gap_wait = 0;
        if (!rst_n) begin
            in_valid <= 1'b0;
            gap_wait = 0;
        end else begin
            if (in_valid && in_ready) begin
                predict_patch(lat_index, lon_index, lower_half);
                cells_accepted++;
            end
            if (!in_valid || in_ready) begin
                if (cell_q.size() != 0 && gap_wait >= cell_q[0].gap) begin
                    head = cell_q.pop_front();
                    lat_index  <= head.lat;
                    lon_index  <= head.lon;
                    lower_half <= head.lower;
                    in_valid   <= 1'b1;
                    gap_wait = 0;
                end else begin
                    in_valid <= 1'b0;
                    if (cell_q.size() != 0) begin
                        gap_wait++;
                    end
                end
            end
        end
    end

    // monitor: check vertex transfers and throttle ready
    always @(posedge i_clk) begin : collect_vertices
        t_vertex   want;
        static int stall_left  = 0;
        static int hold_seen   = 0;
        static bit ready_noisy = 1'b1;
        if (!rst_n) begin
            out_ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (out_valid && out_ready) begin
                vertices_seen++;
                if (vertex_q.size() == 0) begin
                    $error("unexpected vertex: x %0d y %0d z %0d", x_coord, y_coord,
                           z_coord);
                    errors++;
                end else begin
                    want = vertex_q.pop_front();
                    if (x_coord !== want.x) begin
                        $error("x_coord: expected %0d, got %0d", want.x, x_coord);
                        errors++;
                    end
                    if (y_coord !== want.y) begin
                        $error("y_coord: expected %0d, got %0d", want.y, y_coord);
                        errors++;
                    end
                    if (z_coord !== want.z) begin
                        $error("z_coord: expected %0d, got %0d", want.z, z_coord);
                        errors++;
                    end
                    if (red_out !== want.red) begin
                        $error("red_out: expected %0d, got %0d", want.red, red_out);
                        errors++;
                    end
                    if (green_out !== want.green) begin
                        $error("green_out: expected %0d, got %0d", want.green, green_out);
                        errors++;
                    end
                    if (blue_out !== want.blue) begin
                        $error("blue_out: expected %0d, got %0d", want.blue, blue_out);
                        errors++;
                    end
                    if (last_vertex !== want.last) begin
                        $error("last_vertex: expected %0d, got %0d", want.last,
                               last_vertex);
                        errors++;
                    end
                end
            end
            if (hold_seen != hold_asks) begin
                hold_seen  = hold_asks;
                stall_left = LONG_HOLD;
            end
            if ($urandom_range(0, 49) == 0) begin
                ready_noisy = !ready_noisy;
            end
            if (stall_left > 0) begin
                stall_left--;
                out_ready <= 1'b0;
            end else if (ready_noisy && $urandom_range(0, 3) == 0) begin
                stall_left = pick_gap() - 1;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    task automatic queue_cell(int lat, int lon, bit lower, int gap);
        t_cell c;
        c.lat   = lat[LAT_W-1:0];
        c.lon   = lon[LON_W-1:0];
        c.lower = lower;
        c.gap   = gap;
        cell_q.push_back(c);
        cells_queued++;
    endtask

    // mostly on the grid, some beyond it to exercise the wrap
    task automatic queue_random(int n, bit gappy);
        int lat;
        int lon;
        int gap;
        repeat (n) begin
            lat = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 8) : $urandom_range(9, 15);
            lon = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 35)
                                               : $urandom_range(36, 63);
            gap = (gappy && $urandom_range(0, 1)) ? pick_gap() : 0;
            queue_cell(lat, lon, 1'($urandom_range(0, 1)), gap);
        end
    endtask

    // hold until every cell has transferred and every vertex came back
    task automatic wait_idle();
        while (cells_accepted != cells_queued || vertex_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_reg idx, logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            CFG_RADIUS: radius_set = data[RADIUS_W-1:0];
            CFG_RED:    red_set    = data[COLOR_W-1:0];
            CFG_GREEN:  green_set  = data[COLOR_W-1:0];
            CFG_BLUE:   blue_set   = data[COLOR_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic load_settings(logic [CFG_DATA_W-1:0] radius, logic [CFG_DATA_W-1:0] red,
                                 logic [CFG_DATA_W-1:0] green,
                                 logic [CFG_DATA_W-1:0] blue);
        write_reg(CFG_RADIUS, radius);
        write_reg(CFG_RED, red);
        write_reg(CFG_GREEN, green);
        write_reg(CFG_BLUE, blue);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic load_random_settings();
        load_settings(CFG_DATA_W'($urandom_range(0, 32767)),
                      CFG_DATA_W'($urandom_range(0, 32767)),
                      CFG_DATA_W'($urandom_range(0, 32767)),
                      CFG_DATA_W'($urandom_range(0, 32767)));
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        // reset defaults: grid corners, quadrant boundaries, zero z mirrored
        queue_cell(0, 0, 0, 0);
        queue_cell(0, 0, 1, 0);
        queue_cell(8, 35, 0, 0);
        queue_cell(8, 35, 1, 0);
        queue_cell(4, 9, 0, 0);
        queue_cell(4, 18, 1, 0);
        queue_cell(4, 27, 0, 0);
        queue_cell(9, 0, 1, 0);
        queue_cell(13, 20, 0, 0);
        queue_cell(15, 63, 1, 0);
        queue_cell(15, 63, 0, 0);
        queue_cell(7, 35, 1, 0);
        queue_cell(3, 36, 0, 0);
        queue_cell(12, 50, 1, 0);
        wait_idle();

        // largest radius, colour writes wider than the register
        load_settings(15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF);
        queue_cell(0, 0, 0, 0);
        queue_cell(8, 35, 1, 0);
        queue_cell(4, 9, 0, 0);
        queue_cell(15, 63, 1, 0);
        queue_cell(6, 4, 0, 0);
        queue_random(30, 1'b1);
        wait_idle();

        // zero radius, colours zero in the low byte only
        load_settings(15'd0, 15'h7F00, 15'h5A00, 15'h0100);
        queue_cell(0, 0, 0, 0);
        queue_cell(8, 35, 1, 0);
        queue_cell(5, 5, 1, 0);
        queue_random(15, 1'b1);
        wait_idle();

        // back-to-back cells against a long output hold-off
        load_random_settings();
        queue_random(40, 1'b0);
        hold_asks++;
        wait_idle();

        load_random_settings();
        queue_random(15, 1'b0);
        wait_idle();

        load_random_settings();
        queue_random(30, 1'b1);
        wait_idle();

        $display("summary: %0d cells, %0d vertices checked over %0d register settings",
                 cells_accepted, vertices_seen, settings_used);
        $display("summary: radius 0 and max, colour truncation, off-grid wrap, long hold-off");
        if (errors == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
